FILE: sv/gts_pkg.sv
// Shared types, constants and character helpers for the GUID text scanner.
// Used by gts_match and guid_text_scanner; depends on nothing else.
package gts_pkg;

    // Length of one GUID in 8-4-4-4-12 text form, and its hex digit count.
    localparam int GUID_CHARS  = 36;
    localparam int GUID_DIGITS = 32;

    // Default width of the byte position counter.
    localparam int OFFSET_WIDTH_DEF = 32;

    // Width of the reported start offset.
    localparam int START_W = 32;

    // Characters that the pattern checks for.
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;

    // One input transfer.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } in_t;

    // One result transfer.
    typedef struct packed {
        logic [63:0] guid_high;
        logic [63:0] guid_low;
        logic [31:0] upper_case_mask;
        logic [31:0] start_offset;
    } out_t;

    // Window of the last GUID_CHARS bytes; entry 0 is the oldest.
    typedef logic [GUID_CHARS-1:0][7:0] window_t;

    // Pattern slots that must hold a hyphen.
    function automatic logic is_hyphen_slot(input int i);
        return (i == 8) || (i == 13) || (i == 18) || (i == 23);
    endfunction

    // True for an uppercase hex letter.
    function automatic logic is_upper_hex(input logic [7:0] c);
        return (c >= CH_UA) && (c <= CH_UF);
    endfunction

    // True for any hex digit of either case.
    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || is_upper_hex(c) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    // Nibble value of a hex digit; meaningless for other bytes.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = c - CH_0;
        end else if (is_upper_hex(c)) begin
            v = c - CH_UA + 8'd10;
        end else begin
            v = c - CH_LA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

FILE: sv/gts_match.sv
// Pattern check and value extraction for one 36-byte window.
// Depends on gts_pkg for the window type and character helpers.
module gts_match (
    input  gts_pkg::window_t                   window,
    output logic                               pattern_ok,
    output logic [4*gts_pkg::GUID_DIGITS-1:0]  guid_value,
    output logic [gts_pkg::GUID_DIGITS-1:0]    upper_mask
);

    // Each slot is checked on its own; the digit index of a slot is a constant.
    always_comb
    begin
        logic [gts_pkg::GUID_CHARS-1:0] slot_ok;
        logic [$clog2(gts_pkg::GUID_DIGITS)-1:0] digit;
        slot_ok    = '0;
        guid_value = '0;
        upper_mask = '0;
        digit      = '0;
        for (int i = 0; i < gts_pkg::GUID_CHARS; i++)
        begin
            if (gts_pkg::is_hyphen_slot(i))
            begin
                slot_ok[i] = (window[i] == gts_pkg::CH_HYPHEN);
            end
            else
            begin
                slot_ok[i] = gts_pkg::is_hex(window[i]);
                // Digit d occupies bits 127-4d down to 124-4d, whose top bit is {~d, 2'b11}.
                guid_value[{~digit, 2'b11} -: 4] = gts_pkg::hex_nibble(window[i]);
                upper_mask[digit] = gts_pkg::is_upper_hex(window[i]);
                digit = digit + 1'b1;
            end
        end
        pattern_ok = &slot_ok;
    end

endmodule

FILE: sv/guid_text_scanner.sv
// GUID text scanner: finds 8-4-4-4-12 GUIDs in a byte stream.
// Window shift and pattern check are combinational; a result is then registered.
// Throughput: one byte per cycle while byte_stall is low.
// A two-entry output register with skid stage stalls input only when both are full.
// Reset (rst_n, asynchronous, active low) clears the window, counters and valid flags.
// Depends on gts_pkg and gts_match.
module guid_text_scanner #(
    parameter int OFFSET_WIDTH = gts_pkg::OFFSET_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  gts_pkg::in_t  byte_data,
    output logic          guid_valid,
    input  logic          guid_stall,
    output gts_pkg::out_t guid_data
);

    localparam int EXT_W = (OFFSET_WIDTH > gts_pkg::START_W) ? OFFSET_WIDTH
                                                             : gts_pkg::START_W;
    localparam logic [5:0] COUNT_FULL = 6'(gts_pkg::GUID_CHARS);
    localparam logic [5:0] COUNT_LAST = 6'(gts_pkg::GUID_CHARS - 1);

    gts_pkg::window_t          window_reg;
    gts_pkg::window_t          window_next;
    gts_pkg::window_t          window_view;
    logic [5:0]                count_reg;
    logic [5:0]                count_next;
    logic [OFFSET_WIDTH-1:0]   pos_reg;
    logic [OFFSET_WIDTH-1:0]   pos_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    gts_pkg::out_t             out_data_reg;
    gts_pkg::out_t             out_data_next;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;
    gts_pkg::out_t             skid_data_reg;
    gts_pkg::out_t             skid_data_next;

    logic                      accept;
    logic                      pos_sat;
    logic                      pattern_ok;
    logic                      match;
    logic [4*gts_pkg::GUID_DIGITS-1:0] guid_value;
    logic [gts_pkg::GUID_DIGITS-1:0]   upper_mask;
    logic [OFFSET_WIDTH-1:0]   start_pos;
    logic [EXT_W-1:0]          start_ext;
    gts_pkg::out_t             result;

    assign byte_stall = skid_valid_reg;
    assign accept     = byte_valid && !byte_stall;
    assign pos_sat    = (pos_reg == {OFFSET_WIDTH{1'b1}});

    // The window as it stands once the current byte has shifted in.
    always_comb
    begin
        for (int i = 0; i < gts_pkg::GUID_CHARS - 1; i++)
        begin
            window_view[i] = window_reg[i+1];
        end
        window_view[gts_pkg::GUID_CHARS-1] = byte_data.text_byte;
    end

    gts_match u_match (
        .window     (window_view),
        .pattern_ok (pattern_ok),
        .guid_value (guid_value),
        .upper_mask (upper_mask)
    );

    // A match needs a full run of bytes since the last match or text start.
    assign match = accept && (count_reg >= COUNT_LAST) && pattern_ok;

    // Start offset of the match, held at the maximum once the position saturates.
    always_comb
    begin
        start_pos = pos_sat ? pos_reg : pos_reg - OFFSET_WIDTH'(gts_pkg::GUID_CHARS - 1);
        start_ext = EXT_W'(start_pos);
        result.guid_high       = guid_value[127:64];
        result.guid_low        = guid_value[63:0];
        result.upper_case_mask = upper_mask;
        if (start_ext > EXT_W'({gts_pkg::START_W{1'b1}}))
        begin
            result.start_offset = {gts_pkg::START_W{1'b1}};
        end
        else
        begin
            result.start_offset = start_ext[gts_pkg::START_W-1:0];
        end
    end

    // Scanning state: window, run count and byte position.
    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        if (accept)
        begin
            if (byte_data.text_end)
            begin
                window_next = '0;
                count_next  = '0;
                pos_next    = '0;
            end
            else
            begin
                window_next = window_view;
                if (match)
                begin
                    count_next = '0;
                end
                else if (count_reg < COUNT_FULL)
                begin
                    count_next = count_reg + 6'd1;
                end
                if (!pos_sat)
                begin
                    pos_next = pos_reg + OFFSET_WIDTH'(1);
                end
            end
        end
    end

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (!guid_stall)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || !guid_stall)
        begin
            out_valid_next = match;
            out_data_next  = result;
        end
        else if (match)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    // Control and window registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg     <= window_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign guid_valid = out_valid_reg;
    assign guid_data  = out_data_reg;

    // The skid stage only fills behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    // The run count never passes the GUID length.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("run count out of range");

    // A match restarts the run count, so matches cannot overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        match |=> (count_reg == 6'd0))
        else $error("run count not cleared after a match");

    // The end of a text returns the position and count to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_data.text_end) |=> (pos_reg == '0 && count_reg == 6'd0))
        else $error("scanning state not cleared at end of text");

    // A result in the skid stage is held unchanged while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && guid_stall) |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("waiting result in skid stage was lost");

endmodule

FILE: dv/guid_text_scanner_tb.sv
// Self-checking testbench for guid_text_scanner: directed and random texts are
// scanned, and each reported GUID is checked against a model of the scan kept here.
// Depends on gts_pkg and on the guid_text_scanner RTL.
module guid_text_scanner_tb;

    // The DUT is built with a 16-bit position counter, narrower than the start offset.
    localparam int               POS_W      = 16;
    localparam logic [POS_W-1:0] POS_MAX    = '1;
    localparam int               IDLE_LIMIT = 400;
    localparam int               RAND_BYTES = 820;

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          byte_valid = 1'b0;
    logic          guid_stall = 1'b0;
    gts_pkg::in_t  byte_data  = '0;
    logic          byte_stall;
    logic          guid_valid;
    gts_pkg::out_t guid_data;

    // Scan state as the DUT should hold it.
    logic [7:0]       scan_window [0:gts_pkg::GUID_CHARS-1];
    int               chars_since_match;
    logic [POS_W-1:0] text_pos;

    gts_pkg::out_t expected_guids [$];

    int   errors      = 0;
    int   n_bytes     = 0;
    int   n_guids     = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    bit   src_idle_en = 1'b1;
    bit   snk_idle_en = 1'b1;

    guid_text_scanner #(
        .OFFSET_WIDTH(POS_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_data (byte_data),
        .guid_valid(guid_valid),
        .guid_stall(guid_stall),
        .guid_data (guid_data)
    );

    always #5 clk = ~clk;

    // Clears the window, the match distance and the text position.
    function automatic void clear_scan_state();
        for (int i = 0; i < gts_pkg::GUID_CHARS; i++)
        begin
            scan_window[i] = 8'h00;
        end
        chars_since_match = 0;
        text_pos          = '0;
    endfunction

    // Scans one accepted byte and queues the GUID that it completes, if any.
    function automatic void predict_guid_match(input logic [7:0] c, input logic last);
        logic [POS_W-1:0] here;
        logic             at_max;
        logic             ok;
        logic [127:0]     value;
        logic [31:0]      mask;
        logic [63:0]      start;
        logic [7:0]       ch;
        logic [7:0]       d;
        logic [4:0]       digit;
        gts_pkg::out_t    guid;
        here   = text_pos;
        at_max = (here == POS_MAX);
        for (int i = 0; i < gts_pkg::GUID_CHARS - 1; i++)
        begin
            scan_window[i] = scan_window[i + 1];
        end
        scan_window[gts_pkg::GUID_CHARS - 1] = c;
        if (chars_since_match < gts_pkg::GUID_CHARS)
        begin
            chars_since_match++;
        end
        if (!at_max)
        begin
            text_pos = here + 1'b1;
        end

        // Pattern check over the full window, collecting nibbles and the case mask.
        if (chars_since_match >= gts_pkg::GUID_CHARS)
        begin
            ok    = 1'b1;
            value = '0;
            mask  = '0;
            digit = '0;
            for (int i = 0; i < gts_pkg::GUID_CHARS; i++)
            begin
                ch = scan_window[i];
                d  = 8'h00;
                if (i == 8 || i == 13 || i == 18 || i == 23)
                begin
                    if (ch != gts_pkg::CH_HYPHEN)
                    begin
                        ok = 1'b0;
                    end
                end
                else
                begin
                    if (ch >= gts_pkg::CH_0 && ch <= gts_pkg::CH_9)
                    begin
                        d = ch - gts_pkg::CH_0;
                    end
                    else if (ch >= gts_pkg::CH_UA && ch <= gts_pkg::CH_UF)
                    begin
                        d = ch - gts_pkg::CH_UA + 8'd10;
                        mask[digit] = 1'b1;
                    end
                    else if (ch >= gts_pkg::CH_LA && ch <= gts_pkg::CH_LF)
                    begin
                        d = ch - gts_pkg::CH_LA + 8'd10;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                    value = {value[123:0], d[3:0]};
                    digit = digit + 1'b1;
                end
            end
            if (ok)
            begin
                start = at_max ? 64'(POS_MAX) : 64'(here) - 64'(gts_pkg::GUID_CHARS - 1);
                guid.guid_high       = value[127:64];
                guid.guid_low        = value[63:0];
                guid.upper_case_mask = mask;
                guid.start_offset    = (start > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : start[31:0];
                expected_guids = {expected_guids, guid};
                chars_since_match = 0;
            end
        end

        if (last)
        begin
            clear_scan_state();
        end
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Compares one result transfer with the oldest expected GUID.
    task automatic check_guid(input gts_pkg::out_t got);
        gts_pkg::out_t want;
        if (expected_guids.size() == 0)
        begin
            report_mismatch($sformatf("unexpected GUID %h_%h at offset %0d",
                                      got.guid_high, got.guid_low, got.start_offset));
            return;
        end
        want = expected_guids.pop_front();
        n_guids++;
        if (got.guid_high !== want.guid_high)
        begin
            report_mismatch($sformatf("guid_high %h, expected %h", got.guid_high, want.guid_high));
        end
        if (got.guid_low !== want.guid_low)
        begin
            report_mismatch($sformatf("guid_low %h, expected %h", got.guid_low, want.guid_low));
        end
        if (got.upper_case_mask !== want.upper_case_mask)
        begin
            report_mismatch($sformatf("upper_case_mask %h, expected %h",
                                      got.upper_case_mask, want.upper_case_mask));
        end
        if (got.start_offset !== want.start_offset)
        begin
            report_mismatch($sformatf("start_offset %0d, expected %0d",
                                      got.start_offset, want.start_offset));
        end
    endtask

    // Result side: take each transfer, then stall for a random gap if snk_idle_en is set.
    always @(posedge clk)
    begin : guid_sink
        int hold;
        if (rst_n)
        begin
            if (guid_valid && !guid_stall)
            begin
                check_guid(guid_data);
                hold = snk_idle_en ? $urandom_range(0, 8) : 0;
                stall_left <= hold;
                guid_stall <= (hold != 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                guid_stall <= (stall_left > 1);
            end
        end
    end

    // Watchdog: the run ends if no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (guid_valid && !guid_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sends one byte after a random gap if src_idle_en is set; scans it once it is taken.
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid          <= 1'b1;
        byte_data.text_byte <= c;
        byte_data.text_end  <= last;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        n_bytes++;
        predict_guid_match(c, last);
    endtask

    task automatic send_text(input string s, input logic end_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], end_last && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic up);
        if (v < 4'd10)
        begin
            return gts_pkg::CH_0 + 8'(v);
        end
        return (up ? gts_pkg::CH_UA : gts_pkg::CH_LA) + 8'(v) - 8'd10;
    endfunction

    // Sends a GUID with random digits; case_mode 0 lower, 1 upper, 2 mixed.
    // A damaged GUID has one byte replaced by a near-miss, hyphen/digit swap or random byte.
    task automatic send_random_guid(input int case_mode, input bit damaged, input logic last);
        logic [7:0] g [0:gts_pkg::GUID_CHARS-1];
        logic       up;
        int         slot;
        for (int i = 0; i < gts_pkg::GUID_CHARS; i++)
        begin
            up   = (case_mode == 1) || (case_mode == 2 && $urandom_range(0, 1) == 1);
            g[i] = (i == 8 || i == 13 || i == 18 || i == 23)
                   ? gts_pkg::CH_HYPHEN : hex_char(4'($urandom_range(0, 15)), up);
        end
        if (damaged)
        begin
            slot = $urandom_range(0, gts_pkg::GUID_CHARS - 1);
            case ($urandom_range(0, 7))
                0: g[slot] = gts_pkg::CH_0 - 8'd1;
                1: g[slot] = gts_pkg::CH_9 + 8'd1;
                2: g[slot] = gts_pkg::CH_UA - 8'd1;
                3: g[slot] = gts_pkg::CH_UF + 8'd1;
                4: g[slot] = gts_pkg::CH_LA - 8'd1;
                5: g[slot] = gts_pkg::CH_LF + 8'd1;
                6: g[slot] = (g[slot] == gts_pkg::CH_HYPHEN)
                             ? hex_char(4'($urandom_range(0, 15)), 1'b0) : gts_pkg::CH_HYPHEN;
                default: g[slot] = 8'($urandom_range(0, 255));
            endcase
        end
        for (int i = 0; i < gts_pkg::GUID_CHARS; i++)
        begin
            send_byte(g[i], last && (i == gts_pkg::GUID_CHARS - 1));
        end
    endtask

    // Extreme digit values, both cases, and a start offset other than zero.
    task automatic test_plain_guids();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_text("00000000-0000-0000-0000-000000000000", 1'b1);
        send_text("FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF", 1'b1);
        send_text("xffffffff-ffff-ffff-ffff-ffffffffffff", 1'b1);
        send_text("9aB0cD1e-F2a3-4B5c-6D7e-8F9aAbBcCdDe", 1'b0);
        send_text("--01234567-89ab-CDEF-0123-456789ABCDEF!", 1'b1);
    endtask

    // Near-miss or stray bytes, and hyphens or digits in wrong slots, break a match.
    task automatic test_bad_characters();
        string good;
        string bad;
        byte   near_miss [0:7];
        good = "0123abcd-EF45-6789-aBcD-ef0123456789";
        near_miss = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h20, 8'hFF};
        src_idle_en = 1'b0;
        snk_idle_en = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            bad = good;
            bad[(k * 5 + 3) % gts_pkg::GUID_CHARS] = near_miss[k];
            send_text(bad, 1'b0);
            send_text(good, 1'b1);
        end
        // Hex digit in a hyphen slot, hyphen in a digit slot.
        bad = good;
        bad[13] = "7";
        send_text(bad, 1'b1);
        bad = good;
        bad[30] = "-";
        send_text(bad, 1'b1);
    endtask

    // A GUID that shares its first eight digits with the end of the previous match
    // must not be reported; the next disjoint one must be.
    task automatic test_overlap();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b0;
        send_text("aaaaaaaa-aaaa-aaaa-aaaa-aaaaaaaaaaaa-bbbb-bbbb-bbbb-bbbbbbbbbbbb", 1'b0);
        send_text("11111111-2222-3333-4444-555555555555", 1'b0);
        send_text("66666666-7777-8888-9999-AAAAAAAAAAAA", 1'b1);
    endtask

    // text_end in the middle of a GUID drops it; the following text counts from zero.
    task automatic test_text_end();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_text("01234567-89ab-cdef", 1'b1);
        send_text("-0123-456789abcdef", 1'b1);
        send_text("01234567-89ab-cdef-0123-456789abcde", 1'b1);
        send_text("f", 1'b1);
        send_text("fedcba98-7654-3210-FEDC-BA9876543210", 1'b1);
    endtask

    // Mostly well-formed GUIDs with random content, some damaged, some noise between.
    task automatic test_random_texts();
        int   stop_at;
        int   kind;
        int   n;
        logic [7:0] c;
        logic last;
        stop_at = n_bytes + RAND_BYTES;
        while (n_bytes < stop_at)
        begin
            // Idling is switched off now and then to get back-to-back stretches.
            if ($urandom_range(0, 15) == 0)
            begin
                src_idle_en = !src_idle_en;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                snk_idle_en = !snk_idle_en;
            end
            kind = $urandom_range(0, 99);
            last = ($urandom_range(0, 11) == 0);
            if (kind < 55)
            begin
                send_random_guid($urandom_range(0, 2), 1'b0, last);
            end
            else if (kind < 72)
            begin
                send_random_guid($urandom_range(0, 2), 1'b1, last);
            end
            else
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                begin
                    c = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                                     : hex_char(4'($urandom_range(0, 15)),
                                                                1'($urandom_range(0, 1)));
                    send_byte(c, $urandom_range(0, 49) == 0);
                end
            end
        end
        send_byte(gts_pkg::CH_HYPHEN, 1'b1);
    endtask

    initial
    begin
        clear_scan_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_guids();
        test_bad_characters();
        test_overlap();
        test_text_end();
        test_random_texts();

        // Drain the results still in flight.
        byte_valid <= 1'b0;
        while (expected_guids.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        $display("Scanned %0d bytes and checked %0d GUIDs, with %0d mismatches.",
                 n_bytes, n_guids, errors);
        $display("Covered case, bad characters, overlap, text end and random texts.");
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
